[rtl/iirl_pkg.sv]
// ============================================================================
// iirl_pkg
// Types and constants shared by the indexed insert/remove list.
// ============================================================================
package iirl_pkg;

    // Widest cell address; covers the largest supported CAPACITY of 1024.
    localparam int ADDR_BITS = 10;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_SET    = 3'd1,
        REQ_GET    = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_INSERT = 3'd4
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [6:0]  position;
        logic [31:0] item_in;
    } t_req;

    typedef struct packed {
        logic [31:0] item_out;
        logic [6:0]  count;
        t_status     status;
    } t_result;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op               op;
        logic [ADDR_BITS-1:0]   addr;
    } t_cell_cmd;

endpackage

[rtl/iirl_cell.sv]
// ============================================================================
// iirl_cell
// One list entry: holds a word, takes a neighbor's word on a shift, and
// presents its word on the read tap when addressed.
// ============================================================================
module iirl_cell #(
    parameter int WORD_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                  i_clk,
    input  iirl_pkg::t_cell_cmd   i_cmd,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic [WORD_BITS-1:0]  i_prev,
    input  logic [WORD_BITS-1:0]  i_next,
    output logic [WORD_BITS-1:0]  o_data,
    output logic [WORD_BITS-1:0]  o_tap
);

    localparam logic [iirl_pkg::ADDR_BITS-1:0] MY_ADDR = iirl_pkg::ADDR_BITS'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic [WORD_BITS-1:0] r_tap;
    logic                 w_hit;
    logic                 w_above;

    assign w_hit   = (i_cmd.addr == MY_ADDR);
    assign w_above = (MY_ADDR > i_cmd.addr);

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            iirl_pkg::OP_WRITE: begin
                if (w_hit) begin
                    n_data = i_word;
                end
            end
            iirl_pkg::OP_INSERT: begin
                if (w_above) begin
                    n_data = i_prev;
                end else if (w_hit) begin
                    n_data = i_word;
                end
            end
            iirl_pkg::OP_REMOVE: begin
                if (w_above || w_hit) begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // The tap samples the word as it was before this cycle's update.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= w_hit ? r_data : '0;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

[rtl/iirl_read_tree.sv]
// ============================================================================
// iirl_read_tree
// Two-stage registered OR tree that merges the cell taps into one word.
// At most one tap is nonzero at a time.
// ============================================================================
module iirl_read_tree #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic [CAPACITY-1:0][WORD_BITS-1:0]   i_taps,
    output logic [WORD_BITS-1:0]                 o_word
);

    localparam int GRP  = 8;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    logic [NGRP-1:0][WORD_BITS-1:0] w_grp;
    logic [NGRP-1:0][WORD_BITS-1:0] r_grp;
    logic [WORD_BITS-1:0]           w_all;
    logic [WORD_BITS-1:0]           r_word;

    always_comb begin
        w_grp = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | i_taps[g * GRP + k];
                end
            end
        end
    end

    always_comb begin
        w_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_all = w_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= w_grp;
        r_word <= w_all;
    end

    assign o_word = r_word;

endmodule

[rtl/indexed_insert_remove_list.sv]
// ============================================================================
// indexed_insert_remove_list
// Fixed-capacity ordered list with append, set, get, remove and insert.
// ============================================================================
// A request is taken on any clock edge where start is high and busy is low,
// one request per clock; busy is high while reset is asserted and in the
// first cycle after it. Every request returns exactly one result, strobed
// by o_done for a single cycle once it has passed the s0, s1 and done valid
// registers; the receiver cannot stall it. The entries sit in a row of
// cells, so insert and remove shift the whole tail in the same clock as the
// request and the next request already sees the new contents. The result
// is delayed by the read path: the addressed cell's registered tap followed
// by a two-stage registered OR tree. The result count is the entry count
// after the request; status flags a full list or an index beyond the current
// entries, and item_out carries data only for a successful get or remove.
module indexed_insert_remove_list #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  iirl_pkg::t_req    i_req,
    output logic              o_done,
    output iirl_pkg::t_result o_result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    logic                                r_ready;
    logic                                w_accept;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic [CMPW-1:0]                     w_cnt_x;
    logic [CMPW-1:0]                     w_pos_x;
    logic [CMPW-1:0]                     w_cap_x;
    logic [63:0]                         w_in_ext;
    logic [WORD_BITS-1:0]                w_word;
    iirl_pkg::t_cell_cmd                 w_cmd;
    iirl_pkg::t_status                   w_status;
    logic                                w_keep;

    logic [CAPACITY-1:0][WORD_BITS-1:0]  w_data;
    logic [CAPACITY-1:0][WORD_BITS-1:0]  w_taps;
    logic [WORD_BITS-1:0]                w_tree_word;
    logic [63:0]                         w_out_ext;

    logic                                r_s0_valid;
    logic                                r_s1_valid;
    logic                                r_done;
    logic [CW-1:0]                       r_s0_count;
    logic [CW-1:0]                       r_s1_count;
    logic [CW-1:0]                       r_s2_count;
    iirl_pkg::t_status                   r_s0_status;
    iirl_pkg::t_status                   r_s1_status;
    iirl_pkg::t_status                   r_s2_status;
    logic                                r_s0_keep;
    logic                                r_s1_keep;
    logic                                r_s2_keep;

    assign busy     = !r_ready;
    assign w_accept = start && !busy;

    assign w_cnt_x  = CMPW'(r_count);
    assign w_pos_x  = CMPW'(i_req.position);
    assign w_cap_x  = CMPW'(CAPACITY);
    assign w_in_ext = 64'(i_req.item_in);
    assign w_word   = w_in_ext[WORD_BITS-1:0];

    // Request decode: command for the cell row, new count and status.
    always_comb begin
        w_cmd.op   = iirl_pkg::OP_HOLD;
        w_cmd.addr = iirl_pkg::ADDR_BITS'(w_pos_x);
        n_count    = r_count;
        w_status   = iirl_pkg::ST_OK;
        w_keep     = 1'b0;
        case (iirl_pkg::t_req_kind'(i_req.req_type))
            iirl_pkg::REQ_APPEND: begin
                w_cmd.addr = iirl_pkg::ADDR_BITS'(r_count);
                if (w_cnt_x >= w_cap_x) begin
                    w_status = iirl_pkg::ST_FULL;
                end else begin
                    w_cmd.op = iirl_pkg::OP_WRITE;
                    n_count  = r_count + CW'(1);
                end
            end
            iirl_pkg::REQ_SET: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else begin
                    w_cmd.op = iirl_pkg::OP_WRITE;
                end
            end
            iirl_pkg::REQ_GET: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else begin
                    w_keep = 1'b1;
                end
            end
            iirl_pkg::REQ_REMOVE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else begin
                    w_cmd.op = iirl_pkg::OP_REMOVE;
                    w_keep   = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            iirl_pkg::REQ_INSERT: begin
                // The index test takes priority over the full test.
                if (w_pos_x > w_cnt_x) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else if (w_cnt_x >= w_cap_x) begin
                    w_status = iirl_pkg::ST_FULL;
                end else begin
                    w_cmd.op = iirl_pkg::OP_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            default: begin
                w_status = iirl_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_cmd.op = iirl_pkg::OP_HOLD;
            n_count  = r_count;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [WORD_BITS-1:0] w_prev;
            logic [WORD_BITS-1:0] w_next;
            if (gi == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_next
                assign w_next = w_data[gi+1];
            end
            iirl_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX       (gi)
            ) u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_word (w_word),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_data (w_data[gi]),
                .o_tap  (w_taps[gi])
            );
        end
    endgenerate

    iirl_read_tree #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_read_tree (
        .i_clk  (i_clk),
        .i_taps (w_taps),
        .o_word (w_tree_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_count    <= '0;
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_count    <= n_count;
            r_s0_valid <= w_accept;
            r_s1_valid <= r_s0_valid;
            r_done     <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_count  <= n_count;
        r_s0_status <= w_status;
        r_s0_keep   <= w_keep;
        r_s1_count  <= r_s0_count;
        r_s1_status <= r_s0_status;
        r_s1_keep   <= r_s0_keep;
        r_s2_count  <= r_s1_count;
        r_s2_status <= r_s1_status;
        r_s2_keep   <= r_s1_keep;
    end

    assign w_out_ext         = 64'(w_tree_word);
    assign o_done            = r_done;
    assign o_result.item_out = r_s2_keep ? w_out_ext[31:0] : 32'd0;
    assign o_result.count    = 7'(r_s2_count);
    assign o_result.status   = r_s2_status;

    // Every accepted request yields its result strobe on o_done through the valid registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_done)
        else $error("result strobe missing three cycles after a request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 3))
        else $error("result strobe without a matching request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= w_cap_x)
        else $error("entry count exceeds capacity");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.item_out != 32'd0)) |-> (o_result.status == iirl_pkg::ST_OK))
        else $error("data returned with an error status");

endmodule
